// ----- hdl/fcf_pkg.sv -----
// Shared types, codes and constants of the fully connected forward block.
`default_nettype none

package fcf_pkg;

  // Field widths of the stream items
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned IN_IDX_W  = 8;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned IDX_SPAN  = 256;

  // Operation codes carried in the input tuser
  localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_BIAS   = 2'd1;
  localparam logic [OP_W-1:0] OP_ACTIVATION   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_OUTPUTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_INPUTS  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_RES_RD,
    ST_RES_CALC,
    ST_RES_OUT
  } fcf_state_e;

  // One multiply-accumulate request with its operands already read
  typedef struct packed {
    logic                     valid;
    logic [OUT_IDX_W-1:0]     idx;
    logic [DATA_W-1:0]        act;
    logic [DATA_W-1:0]        weight;
    logic [ACC_W-1:0]         acc;
    logic                     acc_vld;
  } mac_req_t;

  // Accumulator write-back from the multiply-accumulate unit
  typedef struct packed {
    logic                     en;
    logic [OUT_IDX_W-1:0]     idx;
    logic [ACC_W-1:0]         data;
  } mac_wr_t;

endpackage

`default_nettype wire

// ----- hdl/fcf_mac.sv -----
// Shared multiply-accumulate unit: registered product, then add into the accumulator.
`default_nettype none

module fcf_mac (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fcf_pkg::mac_req_t req_i,
  output fcf_pkg::mac_wr_t       wr_o
);

  logic signed [fcf_pkg::DATA_W-1:0]   act_s;
  logic signed [fcf_pkg::DATA_W-1:0]   wgt_s;
  logic signed [2*fcf_pkg::DATA_W-1:0] prod_q;
  logic [fcf_pkg::ACC_W-1:0]           base_q;
  logic [fcf_pkg::OUT_IDX_W-1:0]       idx_q;
  logic                                vld_q;

  assign act_s = signed'(req_i.act);
  assign wgt_s = signed'(req_i.weight);

  // Valid flag of the product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.valid;
    end
  end

  // Product stage; an accumulator that is not valid counts as zero.
  always_ff @(posedge clk_i) begin
    prod_q <= act_s * wgt_s;
    base_q <= req_i.acc_vld ? req_i.acc : '0;
    idx_q  <= req_i.idx;
  end

  // Sign-extend the Q16.16 product and add; the accumulator wraps.
  always_comb begin
    wr_o.en   = vld_q;
    wr_o.idx  = idx_q;
    wr_o.data = base_q + {{(fcf_pkg::ACC_W - 2*fcf_pkg::DATA_W){prod_q[2*fcf_pkg::DATA_W-1]}},
                          prod_q};
  end

endmodule

`default_nettype wire

// ----- hdl/fully_connected_forward.sv -----
// Top level of the fully connected forward block: stores, sequencer and result stage.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         tvalid / tready                weight, bias or activation request
//  m_axis    out        tvalid / tready                one result per active output
//  cfg       in         cfg_we_i (no wait)             bias enable, active outputs/inputs
//
// An activation element steps through the N active outputs: one shared multiply-accumulate
// unit visits every output once, then the two-stage pipeline (store read, product) drains.
// On the last input position each result is then read, rounded and handed over, with any
// wait on m_axis_tready.
// Reset clears control state and marks all accumulators zero; stores need no clearing.
// The block takes no new request until all results of the current one are delivered.
`default_nettype none

module fully_connected_forward #(
  parameter int unsigned MAX_OUTPUTS = 64,
  parameter int unsigned MAX_INPUTS  = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // out_index[5:0], in_index[13:6], value[29:14]
  input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // neuron[5:0], activation_out[21:6]
  output logic             m_axis_tuser,  // clipped[0]
  output logic             m_axis_tlast,  // last_result
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i
);

  localparam int unsigned KSPAN  = (MAX_INPUTS < fcf_pkg::IDX_SPAN) ? MAX_INPUTS
                                                                    : fcf_pkg::IDX_SPAN;
  localparam int unsigned WDEPTH = MAX_OUTPUTS * KSPAN;
  localparam int unsigned WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned OUT_AW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  // Unpacked request fields
  logic [fcf_pkg::OP_W-1:0]      op;
  logic [fcf_pkg::OUT_IDX_W-1:0] oi;
  logic [fcf_pkg::IN_IDX_W-1:0]  ii;
  logic [fcf_pkg::DATA_W-1:0]    val;

  assign oi  = s_axis_tdata[5:0];
  assign ii  = s_axis_tdata[13:6];
  assign val = s_axis_tdata[29:14];
  assign op  = s_axis_tuser;

  // Configuration registers
  logic       bias_en_q;
  logic [6:0] act_out_q;
  logic [8:0] act_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_en_q <= 1'b1;
      act_out_q <= 7'd64;
      act_in_q  <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcf_pkg::REG_BIAS_ENABLE:    bias_en_q <= cfg_data_i[0];
        fcf_pkg::REG_ACTIVE_OUTPUTS: act_out_q <= cfg_data_i[6:0];
        fcf_pkg::REG_ACTIVE_INPUTS:  act_in_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the active counts to the sizes that are built.
  logic [6:0]        n_eff;
  logic [8:0]        k_eff;
  logic [OUT_AW-1:0] n_last;
  logic              ii_ok;
  logic              ii_last;

  always_comb begin
    if (act_out_q == 7'd0) begin
      n_eff = 7'd1;
    end else if (act_out_q > 7'(MAX_OUTPUTS)) begin
      n_eff = 7'(MAX_OUTPUTS);
    end else begin
      n_eff = act_out_q;
    end
    if (act_in_q == 9'd0) begin
      k_eff = 9'd1;
    end else if (act_in_q > 9'(KSPAN)) begin
      k_eff = 9'(KSPAN);
    end else begin
      k_eff = act_in_q;
    end
    n_last  = OUT_AW'(n_eff - 7'd1);
    ii_ok   = {1'b0, ii} < k_eff;
    ii_last = {1'b0, ii} == (k_eff - 9'd1);
  end

  // Sequencer registers
  fcf_pkg::fcf_state_e        state_q, state_d;
  logic [OUT_AW-1:0]          n_q, n_d;
  logic [WAW-1:0]             waddr_q, waddr_d;
  logic [fcf_pkg::DATA_W-1:0] act_q, act_d;
  logic                       fire_q, fire_d;
  logic                       drain_q, drain_d;
  logic                       m_valid_q, m_valid_d;

  // Store and pipeline controls
  logic                       wmem_we;
  logic [WAW-1:0]             wmem_waddr;
  logic                       bmem_we;
  logic                       mac_issue;
  logic                       acc_clear;
  logic                       out_load;

  // Stores and their registered read ports
  logic [fcf_pkg::DATA_W-1:0] wmem [WDEPTH];
  logic [fcf_pkg::DATA_W-1:0] bmem [MAX_OUTPUTS];
  logic [fcf_pkg::ACC_W-1:0]  amem [MAX_OUTPUTS];
  logic [MAX_OUTPUTS-1:0]     acc_vld_q;
  logic [fcf_pkg::DATA_W-1:0] w_rd_q;
  logic [fcf_pkg::DATA_W-1:0] b_rd_q;
  logic [fcf_pkg::ACC_W-1:0]  acc_rd_q;
  logic                       accv_rd_q;
  logic                       rd_vld_q;
  logic [OUT_AW-1:0]          rd_idx_q;

  fcf_pkg::mac_req_t mac_req;
  fcf_pkg::mac_wr_t  mac_wr;

  assign wmem_waddr = WAW'(32'(oi) * KSPAN + 32'(ii));

  // Weight store: written by requests, read at the sequencer's address.
  always_ff @(posedge clk_i) begin
    if (wmem_we) begin
      wmem[wmem_waddr] <= val;
    end
    w_rd_q <= wmem[waddr_q];
  end

  // Bias store.
  always_ff @(posedge clk_i) begin
    if (bmem_we) begin
      bmem[oi[OUT_AW-1:0]] <= val;
    end
    b_rd_q <= bmem[n_q];
  end

  // Accumulator store: write-back from the unit, read at the current output.
  always_ff @(posedge clk_i) begin
    if (mac_wr.en) begin
      amem[mac_wr.idx[OUT_AW-1:0]] <= mac_wr.data;
    end
    acc_rd_q  <= amem[n_q];
    accv_rd_q <= acc_vld_q[n_q];
    rd_idx_q  <= n_q;
  end

  // Accumulator valid bits: an entry that is not valid reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= mac_issue;
      if (acc_clear) begin
        acc_vld_q <= '0;
      end else if (mac_wr.en) begin
        acc_vld_q[mac_wr.idx[OUT_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Shared multiply-accumulate unit.
  always_comb begin
    mac_req.valid   = rd_vld_q;
    mac_req.idx     = fcf_pkg::OUT_IDX_W'(rd_idx_q);
    mac_req.act     = act_q;
    mac_req.weight  = w_rd_q;
    mac_req.acc     = acc_rd_q;
    mac_req.acc_vld = accv_rd_q;
  end

  fcf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .wr_o   (mac_wr)
  );

  // Result rounding (half up) and saturation to signed Q8.8.
  logic signed [41:0]         acc_ext;
  logic signed [41:0]         bias_term;
  logic signed [41:0]         sum;
  logic [33:0]                rnd;
  logic                       clip;
  logic [fcf_pkg::DATA_W-1:0] res;

  always_comb begin
    acc_ext   = accv_rd_q ? {{2{acc_rd_q[fcf_pkg::ACC_W-1]}}, acc_rd_q} : '0;
    bias_term = bias_en_q ? {{18{b_rd_q[fcf_pkg::DATA_W-1]}}, b_rd_q, 8'h80} : 42'sd128;
    sum       = acc_ext + bias_term;
    rnd       = sum[41:fcf_pkg::FRAC_BITS];
    clip      = !((&rnd[33:15]) || !(|rnd[33:15]));
    if (!clip) begin
      res = rnd[15:0];
    end else if (rnd[33]) begin
      res = 16'h8000;
    end else begin
      res = 16'h7FFF;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    waddr_d       = waddr_q;
    act_d         = act_q;
    fire_d        = fire_q;
    drain_d       = drain_q;
    m_valid_d     = m_valid_q;
    s_axis_tready = 1'b0;
    wmem_we       = 1'b0;
    bmem_we       = 1'b0;
    mac_issue     = 1'b0;
    acc_clear     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      fcf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (op)
            fcf_pkg::OP_WRITE_WEIGHT: begin
              wmem_we = ({1'b0, oi} < 7'(MAX_OUTPUTS)) && ({1'b0, ii} < 9'(KSPAN));
            end
            fcf_pkg::OP_WRITE_BIAS: begin
              bmem_we = {1'b0, oi} < 7'(MAX_OUTPUTS);
            end
            fcf_pkg::OP_ACTIVATION: begin
              if (ii_ok) begin
                act_d   = val;
                n_d     = '0;
                waddr_d = WAW'(ii);
                fire_d  = ii_last;
                state_d = fcf_pkg::ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      fcf_pkg::ST_MAC: begin
        mac_issue = 1'b1;
        if (n_q == n_last) begin
          drain_d = 1'b0;
          state_d = fcf_pkg::ST_DRAIN;
        end else begin
          n_d     = n_q + 1'b1;
          waddr_d = waddr_q + WAW'(KSPAN);
        end
      end
      fcf_pkg::ST_DRAIN: begin
        if (drain_q) begin
          n_d     = '0;
          state_d = fire_q ? fcf_pkg::ST_RES_RD : fcf_pkg::ST_IDLE;
        end else begin
          drain_d = 1'b1;
        end
      end
      fcf_pkg::ST_RES_RD: begin
        state_d = fcf_pkg::ST_RES_CALC;
      end
      fcf_pkg::ST_RES_CALC: begin
        out_load  = 1'b1;
        m_valid_d = 1'b1;
        state_d   = fcf_pkg::ST_RES_OUT;
      end
      fcf_pkg::ST_RES_OUT: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          if (m_axis_tlast) begin
            acc_clear = 1'b1;
            state_d   = fcf_pkg::ST_IDLE;
          end else begin
            n_d     = n_q + 1'b1;
            state_d = fcf_pkg::ST_RES_RD;
          end
        end
      end
      default: begin
        state_d = fcf_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcf_pkg::ST_IDLE;
      n_q       <= '0;
      fire_q    <= 1'b0;
      drain_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      fire_q    <= fire_d;
      drain_q   <= drain_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers: element value, weight address and the result held for output.
  logic [fcf_pkg::OUT_IDX_W-1:0] neuron_q;
  logic [fcf_pkg::DATA_W-1:0]    res_q;
  logic                          clip_q;
  logic                          last_q;

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    waddr_q <= waddr_d;
    if (out_load) begin
      neuron_q <= fcf_pkg::OUT_IDX_W'(n_q);
      res_q    <= res;
      clip_q   <= clip;
      last_q   <= (n_q == n_last);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, res_q, neuron_q};
  assign m_axis_tuser  = clip_q;
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

// ----- hdl/fcf_checker.sv -----
// Port-level checks of the fully connected forward block, bound to its top level.
`default_nettype none

module fcf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic out_hs;

  assign out_hs = m_axis_tvalid && m_axis_tready;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Requests are never taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request ready while a result is pending");

  // Between results of one vector the block stays busy.
  a_busy_mid_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && !m_axis_tlast |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block left the result phase early");

  // After the last result the block is ready again.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && m_axis_tlast |=> s_axis_tready)
    else $error("block not ready after the last result");

  // A saturated result sits at one of the two limits.
  a_clip_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[21:6] == 16'h7FFF) || (m_axis_tdata[21:6] == 16'h8000))
    else $error("clipped result not at a limit");

endmodule

bind fully_connected_forward fcf_checker u_fcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- sim/fully_connected_forward_tb.sv -----
// Self-checking testbench for the fully connected forward block.
`timescale 1ns / 1ps

module fully_connected_forward_tb;
  import fcf_pkg::*;

  // Operation code that the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned MAX_OUTPUTS = 64;
  localparam int unsigned MAX_INPUTS  = 256;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ACTIVATIONS = 100;
  localparam int unsigned DIRECTED_COUNT = 22;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] neuron;
    logic [DATA_W-1:0]    act;
    logic                 clipped;
    logic                 last;
  } neuron_result_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [OUT_IDX_W-1:0] oi;
    logic [IN_IDX_W-1:0]  ii;
    logic [DATA_W-1:0]    val;
    logic                 has_exp;
    logic [DATA_W-1:0]    exp_act;
    logic                 exp_clip;
  } dir_row_t;

  // Directed rows run with bias on, one output and one input position, so every
  // activation in range closes a vector with a single result for neuron zero.
  localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{OP_WRITE_WEIGHT, 6'd0,  8'd0,   16'h0100, 1'b0, 16'h0000, 1'b0},
    '{OP_WRITE_BIAS,   6'd0,  8'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h0100, 1'b1, 16'h0100, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h8000, 1'b1, 16'h8000, 1'b0},
    '{OP_WRITE_WEIGHT, 6'd0,  8'd0,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h7FFF, 1'b1, 16'h7FFF, 1'b1},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h8000, 1'b1, 16'h8000, 1'b1},
    '{OP_WRITE_BIAS,   6'd0,  8'd0,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{OP_WRITE_WEIGHT, 6'd0,  8'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h1234, 1'b1, 16'h7FFF, 1'b0},
    '{OP_WRITE_BIAS,   6'd0,  8'd0,   16'h8000, 1'b0, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'hFFFF, 1'b1, 16'h8000, 1'b0},
    '{OP_UNUSED,       6'd63, 8'd255, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd1,   16'h5555, 1'b0, 16'h0000, 1'b0},
    '{OP_WRITE_WEIGHT, 6'd63, 8'd255, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_WRITE_BIAS,   6'd63, 8'd0,   16'h0001, 1'b0, 16'h0000, 1'b0},
    '{OP_WRITE_WEIGHT, 6'd0,  8'd0,   16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_WRITE_BIAS,   6'd0,  8'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h0080, 1'b1, 16'h0000, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'hFF80, 1'b1, 16'h0001, 1'b0},
    '{OP_ACTIVATION,   6'd0,  8'd0,   16'h4000, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // out_index[5:0], in_index[13:6], value[29:14]
  logic [1:0]  s_axis_tuser = '0;  // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // neuron[5:0], activation_out[21:6]
  logic        m_axis_tuser;       // clipped[0]
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  // Mirror of the layer: stores, accumulators and register values
  logic signed [DATA_W-1:0] weight_mem [MAX_OUTPUTS][MAX_INPUTS];
  bit                       weight_ok  [MAX_OUTPUTS][MAX_INPUTS];
  logic signed [DATA_W-1:0] bias_mem   [MAX_OUTPUTS];
  bit          [ACC_W-1:0]  acc_mem    [MAX_OUTPUTS];
  bit                       cfg_bias_en = 1'b1;
  int unsigned              cfg_outputs = 64;
  int unsigned              cfg_inputs = 256;

  neuron_result_t due_results [$];
  int unsigned    results_last_request;
  int unsigned    mismatch_count = 0;
  int unsigned    acts_sent = 0;
  int unsigned    cycle_count = 0;
  int unsigned    sink_wait = 0;
  bit             no_idle = 1'b0;

  fully_connected_forward dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Register values are clamped to the legal range when used.
  function automatic int unsigned outputs_in_use();
    if (cfg_outputs < 1) return 1;
    if (cfg_outputs > MAX_OUTPUTS) return MAX_OUTPUTS;
    return cfg_outputs;
  endfunction

  function automatic int unsigned inputs_in_use();
    if (cfg_inputs < 1) return 1;
    if (cfg_inputs > MAX_INPUTS) return MAX_INPUTS;
    return cfg_inputs;
  endfunction

  // Applies one accepted request to the mirror and queues the results it causes.
  function automatic int unsigned apply_to_layer(input logic [OP_W-1:0] op,
                                                 input logic [OUT_IDX_W-1:0] oi,
                                                 input logic [IN_IDX_W-1:0] ii,
                                                 input logic [DATA_W-1:0] val);
    int unsigned           n_act;
    int unsigned           k_act;
    logic signed [31:0]    prod;
    longint                sum;
    longint                rounded;
    neuron_result_t        res;
    n_act = outputs_in_use();
    k_act = inputs_in_use();
    case (op)
      OP_WRITE_WEIGHT: begin
        weight_mem[oi][ii] = val;
        weight_ok[oi][ii] = 1'b1;
      end
      OP_WRITE_BIAS: begin
        bias_mem[oi] = val;
      end
      OP_ACTIVATION: begin
        if (ii >= k_act) return 0;
        for (int n = 0; n < n_act; n++) begin
          prod = $signed(val) * weight_mem[n][ii];
          acc_mem[n] = acc_mem[n] + {{8{prod[31]}}, prod};
        end
        if (ii != k_act - 1) return 0;
        // Close the vector: add bias, round half up, saturate to Q8.8.
        for (int n = 0; n < n_act; n++) begin
          sum = longint'($signed(acc_mem[n]));
          if (cfg_bias_en) sum += longint'(bias_mem[n]) * 256;
          rounded = (sum + 128) >>> FRAC_BITS;
          res.clipped = 1'b0;
          if (rounded > 32767) begin
            rounded = 32767;
            res.clipped = 1'b1;
          end else if (rounded < -32768) begin
            rounded = -32768;
            res.clipped = 1'b1;
          end
          res.neuron = n[OUT_IDX_W-1:0];
          res.act = rounded[DATA_W-1:0];
          res.last = (n == n_act - 1);
          due_results.push_back(res);
        end
        for (int n = 0; n < MAX_OUTPUTS; n++) acc_mem[n] = '0;
        return n_act;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // Mostly small Q8.8 values, with full-range and extreme values mixed in.
  function automatic logic [DATA_W-1:0] pick_value();
    int tmp;
    case ($urandom_range(0, 7))
      0: tmp = $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: tmp = 32767;
          1: tmp = -32768;
          2: tmp = -1;
          default: tmp = 1;
        endcase
      end
      default: tmp = $urandom_range(0, 1023) - 512;
    endcase
    return tmp[DATA_W-1:0];
  endfunction

  // Sends one request after a random gap and mirrors it once it is accepted.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [OUT_IDX_W-1:0] oi,
                              input logic [IN_IDX_W-1:0] ii, input logic [DATA_W-1:0] val);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, val, ii, oi};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    results_last_request = apply_to_layer(op, oi, ii, val);
  endtask

  // Holds the input off until every result is in and the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers back to back.
  task automatic program_layer(input logic [8:0] bias_val, input logic [8:0] outs_val,
                               input logic [8:0] ins_val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_BIAS_ENABLE;
    cfg_data_i <= bias_val;
    @(posedge clk_i);
    cfg_index_i <= REG_ACTIVE_OUTPUTS;
    cfg_data_i <= outs_val;
    @(posedge clk_i);
    cfg_index_i <= REG_ACTIVE_INPUTS;
    cfg_data_i <= ins_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_bias_en = bias_val[0];
    cfg_outputs = outs_val[6:0];
    cfg_inputs = ins_val;
  endtask

  // An element reads the weight of every active output at its position,
  // so missing weights are written first.
  task automatic send_activation(input int unsigned pos);
    for (int n = 0; n < outputs_in_use(); n++) begin
      if (!weight_ok[n][pos]) send_request(OP_WRITE_WEIGHT, n[5:0], pos[7:0], pick_value());
    end
    send_request(OP_ACTIVATION, 6'($urandom()), pos[7:0], pick_value());
    acts_sent++;
  endtask

  // Requests that never touch a store entry that was not written.
  task automatic inject_noise(input int unsigned k_act);
    case ($urandom_range(0, 3))
      0: send_request(OP_UNUSED, 6'($urandom()), 8'($urandom()), pick_value());
      1: begin
        if (k_act < MAX_INPUTS) begin
          send_request(OP_ACTIVATION, 6'($urandom()), 8'($urandom_range(k_act, 255)),
                       pick_value());
        end
      end
      2: send_request(OP_WRITE_WEIGHT, 6'($urandom()), 8'($urandom()), pick_value());
      default: send_request(OP_WRITE_BIAS, 6'($urandom()), 8'($urandom()), pick_value());
    endcase
  endtask

  // One input vector: mostly well formed, with skipped, repeated and
  // foreign requests, and now and then a vector that never closes.
  task automatic run_vector();
    int unsigned k_act;
    int unsigned plan [$];
    k_act = inputs_in_use();
    if (k_act <= 12) begin
      for (int p = 0; p + 1 < k_act; p++) plan.push_back(p);
    end else begin
      repeat ($urandom_range(1, 3)) plan.push_back($urandom_range(0, 7));
    end
    foreach (plan[i]) begin
      if ($urandom_range(0, 7) == 0) inject_noise(k_act);
      if ($urandom_range(0, 15) != 0) send_activation(plan[i]);
      if ($urandom_range(0, 15) == 0) send_activation(plan[i]);
    end
    if ($urandom_range(0, 11) != 0) send_activation(k_act - 1);
  endtask

  task automatic run_phase(input logic [8:0] bias_val, input logic [8:0] outs_val,
                           input logic [8:0] ins_val, input int unsigned vectors);
    settle();
    program_layer(bias_val, outs_val, ins_val);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (vectors) run_vector();
  endtask

  // Result checker; also draws the random stall of the result side.
  always @(posedge clk_i) begin : result_check
    neuron_result_t want;
    int unsigned    stall;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: neuron %0d value %h clipped %b last %b",
                   m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tuser, m_axis_tlast);
        end
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[5:0] !== want.neuron || m_axis_tdata[21:6] !== want.act ||
            m_axis_tuser !== want.clipped || m_axis_tlast !== want.last) begin
          if (mismatch_count < 10) begin
            $display("result mismatch: expected neuron %0d value %h clipped %b last %b",
                     want.neuron, want.act, want.clipped, want.last);
            $display("                 got      neuron %0d value %h clipped %b last %b",
                     m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tuser, m_axis_tlast);
          end
          mismatch_count++;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
    end else begin
      stall = sink_wait;
    end
    if (stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_wait <= stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_wait <= 0;
    end
  end

  initial begin : stimulus
    dir_row_t       row;
    neuron_result_t typed;
    logic [8:0]     outs_val;
    logic [8:0]     ins_val;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: bias on, 64 outputs, 256 inputs.
    for (int n = 0; n < MAX_OUTPUTS; n++) send_request(OP_WRITE_BIAS, n[5:0], 8'd0, pick_value());
    for (int n = 0; n < MAX_OUTPUTS; n++) begin
      send_request(OP_WRITE_WEIGHT, n[5:0], 8'd255, pick_value());
    end
    send_activation(255);
    send_activation(255);
    settle();

    // Directed rows on a one-by-one layer.
    program_layer(9'd1, 9'd1, 9'd1);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      send_request(row.op, row.oi, row.ii, row.val);
      if (row.has_exp) begin
        repeat (results_last_request) void'(due_results.pop_back());
        typed.neuron = '0;
        typed.act = row.exp_act;
        typed.clipped = row.exp_clip;
        typed.last = 1'b1;
        due_results.push_back(typed);
      end
    end

    // Register extremes, including values that must be clamped.
    run_phase(9'd0, 9'd64, 9'd1, 3);
    run_phase(9'd1, 9'd1, 9'd256, 3);
    run_phase(9'd1, 9'd0, 9'd0, 4);
    run_phase(9'd0, 9'd127, 9'd511, 2);

    // Random layers, mostly small ones.
    acts_sent = 0;
    while (acts_sent < RANDOM_ACTIVATIONS) begin
      outs_val = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      ins_val = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 256) : $urandom_range(1, 12);
      run_phase($urandom_range(0, 1), outs_val, ins_val, $urandom_range(2, 4));
    end
    settle();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fcf_pkg.sv
hdl/fcf_mac.sv
hdl/fully_connected_forward.sv
hdl/fcf_checker.sv
sim/fully_connected_forward_tb.sv
